[src/i2cblm_pkg.sv]
// i2cblm_pkg: shared constants and types of the bit-level i2c master
// holds command codes, field widths, register indexes and the result item type
// no dependencies
package i2cblm_pkg;

    // width of the delay registers and the tick counter
    localparam int DELAY_BITS = 16;
    // width of the configuration write data
    localparam int CFG_DATA_BITS = 16;
    // configuration register index width
    localparam int CFG_INDEX_BITS = 1;

    // command codes
    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_STOP  = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_ACK   = 3'd4;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_SHORT_DELAY = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LONG_DELAY  = 1'd1;

    // reset values of the delay registers
    localparam logic [DELAY_BITS-1:0] SHORT_DELAY_RESET = DELAY_BITS'(80);
    localparam logic [DELAY_BITS-1:0] LONG_DELAY_RESET  = DELAY_BITS'(160);

    // bits per byte on the bus
    localparam logic [3:0] BYTE_BITS = 4'd8;

    // one result item
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_seen;
    } res_item_t;

endpackage

[src/i2cblm_if.sv]
// i2cblm_if: valid/ready channels of the bit-level i2c master
// command tick channel and result channel; no package dependency

// one tick item: command offer plus sampled sda
interface i2cblm_cmd_if;
    logic       valid;
    logic       ready;
    logic       cmd_valid;
    logic [2:0] op;
    logic [7:0] write_data;
    logic       sda_in;

    modport source (output valid, output cmd_valid, output op, output write_data,
                    output sda_in, input ready);
    modport sink   (input valid, input cmd_valid, input op, input write_data,
                    input sda_in, output ready);
endinterface

// one result item per tick
interface i2cblm_res_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_seen;

    modport source (output valid, output scl_level, output sda_level, output busy_res,
                    output done_res, output read_data, output ack_seen, input ready);
    modport sink   (input valid, input scl_level, input sda_level, input busy_res,
                    input done_res, input read_data, input ack_seen, output ready);
endinterface

[src/i2c_bit_level_master_top.sv]
// Bit-level i2c master: one tick item in, one result item out.
// The result of an accepted tick is registered in the output register, or in the skid entry while the output waits.
// Throughput: one tick item per cycle while the skid entry is empty; the sequencer state advances once per item.
// A two-entry output stage (register plus skid) keeps input ready while a result waits.
// Reset: asynchronous active low; sequencer idle, scl and sda released, delays 80 and 160.
// Depends on i2cblm_pkg and the channel interfaces in i2cblm_if.sv.
module i2c_bit_level_master_top
    import i2cblm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    i2cblm_cmd_if.sink                cmd,
    i2cblm_res_if.source              res
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST1, PH_ST2, PH_SP1, PH_SP2, PH_SP3,
        PH_WBIT, PH_WHI, PH_WLO, PH_AHI, PH_ASMP, PH_AEND,
        PH_RHI, PH_RSMP, PH_K1, PH_K2, PH_K3
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [DELAY_BITS-1:0] wait_reg, wait_next;
    logic [3:0]            bit_count_reg, bit_count_next;
    logic [7:0]            shift_reg, shift_next;
    logic                  scl_reg, scl_next;
    logic                  sda_reg, sda_next;
    logic                  ack_reg, ack_next;
    logic [7:0]            read_byte_reg, read_byte_next;
    logic [DELAY_BITS-1:0] short_delay_reg, long_delay_reg;

    res_item_t             out_reg, skid_reg, result;
    logic                  out_valid_reg, skid_valid_reg;

    logic                  accept, out_fire, done_c;
    logic [DELAY_BITS-1:0] eff_short, eff_long;
    logic [3:0]            bit_inc;
    logic [7:0]            shift_in;
    logic [DELAY_BITS-1:0] cfg_value;

    assign accept   = cmd.valid && cmd.ready;
    assign out_fire = out_valid_reg && res.ready;
    assign cmd.ready = !skid_valid_reg;

    // a zero delay waits one tick
    assign eff_short = (short_delay_reg == '0) ? DELAY_BITS'(1) : short_delay_reg;
    assign eff_long  = (long_delay_reg == '0) ? DELAY_BITS'(1) : long_delay_reg;
    assign bit_inc   = bit_count_reg + 4'd1;
    assign shift_in  = {shift_reg[6:0], cmd.sda_in};
    assign cfg_value = DELAY_BITS'(cfg_data);

    // sequencer step for one tick
    always_comb
    begin
        phase_next     = phase_reg;
        wait_next      = wait_reg;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        ack_next       = ack_reg;
        read_byte_next = read_byte_reg;
        done_c         = 1'b0;
        if (phase_reg == PH_IDLE)
        begin
            // command start; unknown codes are dropped
            if (cmd.cmd_valid)
            begin
                unique case (cmd.op)
                    OP_START:
                    begin
                        bit_count_next = 4'd0;
                        phase_next     = PH_ST1;
                        wait_next      = eff_long;
                    end
                    OP_STOP:
                    begin
                        bit_count_next = 4'd0;
                        scl_next       = 1'b1;
                        phase_next     = PH_SP1;
                        wait_next      = eff_short;
                    end
                    OP_WRITE:
                    begin
                        bit_count_next = 4'd0;
                        shift_next     = cmd.write_data;
                        scl_next       = 1'b0;
                        phase_next     = PH_WBIT;
                        wait_next      = eff_short;
                    end
                    OP_READ:
                    begin
                        bit_count_next = 4'd0;
                        shift_next     = 8'd0;
                        sda_next       = 1'b1;
                        scl_next       = 1'b0;
                        phase_next     = PH_RHI;
                        wait_next      = eff_long;
                    end
                    OP_ACK:
                    begin
                        bit_count_next = 4'd0;
                        scl_next       = 1'b0;
                        phase_next     = PH_K1;
                        wait_next      = eff_short;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
        else if (wait_reg > DELAY_BITS'(1))
        begin
            wait_next = wait_reg - DELAY_BITS'(1);
        end
        else
        begin
            // wait over: take the phase action
            wait_next = '0;
            unique case (phase_reg)
                PH_ST1:
                begin
                    sda_next   = 1'b0;
                    phase_next = PH_ST2;
                    wait_next  = eff_short;
                end
                PH_ST2:
                begin
                    scl_next   = 1'b0;
                    phase_next = PH_IDLE;
                    done_c     = 1'b1;
                end
                PH_SP1:
                begin
                    sda_next   = 1'b0;
                    phase_next = PH_SP2;
                    wait_next  = eff_long;
                end
                PH_SP2:
                begin
                    sda_next   = 1'b1;
                    phase_next = PH_SP3;
                    wait_next  = eff_long;
                end
                PH_WBIT:
                begin
                    sda_next   = shift_reg[7];
                    shift_next = {shift_reg[6:0], 1'b0};
                    phase_next = PH_WHI;
                    wait_next  = eff_short;
                end
                PH_WHI:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_WLO;
                    wait_next  = eff_long;
                end
                PH_WLO:
                begin
                    scl_next       = 1'b0;
                    bit_count_next = bit_inc;
                    if (bit_inc < BYTE_BITS)
                    begin
                        phase_next = PH_WBIT;
                        wait_next  = eff_short;
                    end
                    else
                    begin
                        sda_next   = 1'b1;
                        phase_next = PH_AHI;
                        wait_next  = eff_long;
                    end
                end
                PH_AHI:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_ASMP;
                    wait_next  = eff_long;
                end
                PH_ASMP:
                begin
                    ack_next   = !cmd.sda_in;
                    scl_next   = 1'b0;
                    phase_next = PH_AEND;
                    wait_next  = eff_short;
                end
                PH_RHI:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_RSMP;
                    wait_next  = eff_long;
                end
                PH_RSMP:
                begin
                    shift_next     = shift_in;
                    bit_count_next = bit_inc;
                    scl_next       = 1'b0;
                    if (bit_inc < BYTE_BITS)
                    begin
                        phase_next = PH_RHI;
                        wait_next  = eff_long;
                    end
                    else
                    begin
                        read_byte_next = shift_in;
                        phase_next     = PH_IDLE;
                        done_c         = 1'b1;
                    end
                end
                PH_K1:
                begin
                    sda_next   = 1'b0;
                    phase_next = PH_K2;
                    wait_next  = eff_short;
                end
                PH_K2:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_K3;
                    wait_next  = eff_long;
                end
                PH_K3:
                begin
                    scl_next   = 1'b0;
                    phase_next = PH_IDLE;
                    done_c     = 1'b1;
                end
                default:
                begin
                    // stop end, ack end and any stray phase just finish
                    phase_next = PH_IDLE;
                    done_c     = 1'b1;
                end
            endcase
        end
    end

    // result item of this tick
    always_comb
    begin
        result.scl_level = scl_next;
        result.sda_level = sda_next;
        result.busy_res  = (phase_next != PH_IDLE);
        result.done_res  = done_c;
        result.read_data = read_byte_next;
        result.ack_seen  = ack_next;
    end

    // sequencer state, delay registers and output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            wait_reg        <= '0;
            bit_count_reg   <= 4'd0;
            shift_reg       <= 8'd0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            ack_reg         <= 1'b0;
            read_byte_reg   <= 8'd0;
            short_delay_reg <= SHORT_DELAY_RESET;
            long_delay_reg  <= LONG_DELAY_RESET;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            // configuration writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SHORT_DELAY: short_delay_reg <= cfg_value;
                    REG_LONG_DELAY:  long_delay_reg  <= cfg_value;
                    default:         short_delay_reg <= short_delay_reg;
                endcase
            end
            // advance on each accepted tick
            if (accept)
            begin
                phase_reg     <= phase_next;
                wait_reg      <= wait_next;
                bit_count_reg <= bit_count_next;
                shift_reg     <= shift_next;
                scl_reg       <= scl_next;
                sda_reg       <= sda_next;
                ack_reg       <= ack_next;
                read_byte_reg <= read_byte_next;
            end
            // output register with skid entry
            if (accept)
            begin
                if (!out_valid_reg || out_fire)
                begin
                    out_reg       <= result;
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_reg       <= result;
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_fire)
            begin
                if (skid_valid_reg)
                begin
                    out_reg        <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.scl_level = out_reg.scl_level;
    assign res.sda_level = out_reg.sda_level;
    assign res.busy_res  = out_reg.busy_res;
    assign res.done_res  = out_reg.done_res;
    assign res.read_data = out_reg.read_data;
    assign res.ack_seen  = out_reg.ack_seen;

    // skid entry only fills behind a waiting output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds an item while output register is empty");

    // idle sequencer has no pending wait
    a_idle_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (wait_reg == '0))
        else $error("wait counter running while idle");

    // a running phase always has a wait of at least one tick
    a_busy_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> (wait_reg != '0))
        else $error("running phase with zero wait");

    // a valid command taken while idle starts a sequence
    a_cmd_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_IDLE && cmd.cmd_valid &&
         (cmd.op == OP_START || cmd.op == OP_STOP || cmd.op == OP_WRITE ||
          cmd.op == OP_READ || cmd.op == OP_ACK)) |=> (phase_reg != PH_IDLE))
        else $error("accepted command did not start a sequence");

    // bit counter never passes one byte
    a_bit_count: assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg <= BYTE_BITS)
        else $error("bit counter past eight");

    // a finished sequence reports not busy
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.done_res) |-> !out_reg.busy_res)
        else $error("done reported while busy");

endmodule
